>>> rtl/skpl_pkg.sv
// shared constants and types for the sorted key position lookup
// used by skpl_ctrl, skpl_dp and sorted_key_position_lookup; no dependencies
package skpl_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH) + 1;
    localparam int KEY_W  = 37;
    localparam int POS_W  = 6;

    // one stored entry: key and its load-order tag
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] tag;
    } skpl_entry_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic append;
        logic pass_start;
        logic load_carry;
        logic pass_step;
        logic pass_end;
        logic mark_sorted;
        logic srch_init;
        logic srch_read;
        logic srch_step;
        logic emit_miss;
    } skpl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_sorted;
        logic count_ge2;
        logic pass_last;
        logic swapped;
        logic srch_empty;
        logic srch_hit;
    } skpl_status_t;

endpackage

>>> rtl/sorted_key_position_lookup.sv
// top level of the sorted key position lookup
// depends on skpl_pkg, skpl_ctrl and skpl_dp
//
// usage:
//   a transaction is accepted on a rising edge with start high and busy low;
//   action, first and key are sampled at that edge.
//   append (action 0): stores the key with its load-order tag,
//   busy stays low, no result. first empties the set before the key goes in;
//   appends past DEPTH keys are dropped.
//   search (action 1): busy rises; if the set changed since the last search
//   and holds two or more entries, bubble sort passes run over the entry
//   memory, up to n passes for n entries, one memory read and one write
//   per cycle. then a binary search runs, each probe a read and then a
//   compare, at most log2(n)+1 probes over the sorted entries.
//   the result (found, position) appears for one cycle with done high and
//   busy falls in the same cycle; the receiver cannot stall, so nothing waits.
//   reset empties the set and marks it unsorted; the memory itself is not
//   cleared since only loaded entries are ever used.
module sorted_key_position_lookup
    import skpl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             action,
    input  logic             first,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic             found,
    output logic [POS_W-1:0] position
);

    skpl_cmd_t    cmd;
    skpl_status_t status;

    // sequencer
    skpl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // storage, sort and search datapath
    skpl_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .first    (first),
        .key      (key),
        .done     (done),
        .found    (found),
        .position (position)
    );

endmodule

>>> rtl/skpl_dp.sv
// datapath: entry memory, entry count, bubble sort carry and binary search bounds
// depends on skpl_pkg
module skpl_dp
    import skpl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  skpl_cmd_t          cmd,
    output skpl_status_t       status,
    input  logic               first,
    input  logic [KEY_W-1:0]   key,
    output logic               done,
    output logic               found,
    output logic [POS_W-1:0]   position
);

    skpl_entry_t mem [DEPTH];

    skpl_entry_t       rdata_reg;
    skpl_entry_t       carry_reg, carry_next;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              sorted_reg, sorted_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              swapped_reg, swapped_next;
    logic [CNT_W-1:0]  low_reg, low_next;
    logic [CNT_W-1:0]  hp1_reg, hp1_next;
    logic [ADDR_W-1:0] mid_reg, mid_next;
    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic [POS_W-1:0]  position_reg, position_next;

    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    skpl_entry_t       wr_data;
    logic [ADDR_W-1:0] last_addr;
    logic [CNT_W:0]    mid_sum;
    logic [ADDR_W-1:0] mid_calc;
    logic              carry_gt;
    logic              set_full;

    assign last_addr = ADDR_W'(count_reg - CNT_W'(1));
    assign mid_sum   = {1'b0, low_reg} + {1'b0, hp1_reg} - (CNT_W+1)'(1);
    assign mid_calc  = ADDR_W'(mid_sum >> 1);
    assign carry_gt  = carry_reg.key > rdata_reg.key;
    assign set_full  = count_reg >= CNT_W'(DEPTH);

    // status toward the controller
    always_comb
    begin
        status.is_sorted  = sorted_reg;
        status.count_ge2  = count_reg >= CNT_W'(2);
        status.pass_last  = idx_reg == last_addr;
        status.swapped    = swapped_reg;
        status.srch_empty = low_reg >= hp1_reg;
        status.srch_hit   = rdata_reg.key == key_reg;
    end

    // memory read address
    always_comb
    begin
        rd_addr = '0;
        if (cmd.load_carry)
        begin
            rd_addr = ADDR_W'(1);
        end
        else if (cmd.pass_step)
        begin
            rd_addr = idx_reg + ADDR_W'(1);
        end
        else if (cmd.srch_read)
        begin
            rd_addr = mid_calc;
        end
    end

    // memory write port and next state
    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = carry_reg;
        carry_next    = carry_reg;
        count_next    = count_reg;
        sorted_next   = sorted_reg;
        idx_next      = idx_reg;
        swapped_next  = swapped_reg;
        low_next      = low_reg;
        hp1_next      = hp1_reg;
        mid_next      = mid_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        position_next = position_reg;

        // append, optionally emptying the set first
        if (cmd.append)
        begin
            if (first)
            begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data.key = key;
                wr_data.tag = '0;
                count_next  = CNT_W'(1);
                sorted_next = 1'b0;
            end
            else if (!set_full)
            begin
                wr_en       = 1'b1;
                wr_addr     = ADDR_W'(count_reg);
                wr_data.key = key;
                wr_data.tag = ADDR_W'(count_reg);
                count_next  = count_reg + CNT_W'(1);
                sorted_next = 1'b0;
            end
        end

        // bubble sort pass: the larger entry rides along in the carry
        if (cmd.pass_start)
        begin
            swapped_next = 1'b0;
        end
        if (cmd.load_carry)
        begin
            carry_next = rdata_reg;
            idx_next   = ADDR_W'(1);
        end
        if (cmd.pass_step)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg - ADDR_W'(1);
            if (carry_gt)
            begin
                wr_data      = rdata_reg;
                swapped_next = 1'b1;
            end
            else
            begin
                wr_data    = carry_reg;
                carry_next = rdata_reg;
            end
            idx_next = idx_reg + ADDR_W'(1);
        end
        if (cmd.pass_end)
        begin
            wr_en   = 1'b1;
            wr_addr = last_addr;
            wr_data = carry_reg;
        end
        if (cmd.mark_sorted)
        begin
            sorted_next = 1'b1;
        end

        // binary search over [low, hp1)
        if (cmd.srch_init)
        begin
            low_next = '0;
            hp1_next = count_reg;
        end
        if (cmd.srch_read)
        begin
            mid_next = mid_calc;
        end
        if (cmd.srch_step)
        begin
            if (status.srch_hit)
            begin
                done_next     = 1'b1;
                found_next    = 1'b1;
                position_next = POS_W'(rdata_reg.tag);
            end
            else if (key_reg > rdata_reg.key)
            begin
                low_next = CNT_W'(mid_reg) + CNT_W'(1);
            end
            else
            begin
                hp1_next = CNT_W'(mid_reg);
            end
        end
        if (cmd.emit_miss)
        begin
            done_next     = 1'b1;
            found_next    = 1'b0;
            position_next = '0;
        end
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        idx_reg   <= idx_next;
        low_reg   <= low_next;
        hp1_reg   <= hp1_next;
        mid_reg   <= mid_next;
        if (cmd.capture)
        begin
            key_reg <= key;
        end
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sorted_reg   <= 1'b0;
            swapped_reg  <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            position_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            sorted_reg   <= sorted_next;
            swapped_reg  <= swapped_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
            position_reg <= position_next;
        end
    end

    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;

endmodule

>>> rtl/skpl_ctrl.sv
// controller: sequences appends, bubble sort passes and binary search steps
// depends on skpl_pkg
module skpl_ctrl
    import skpl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         action,
    input  skpl_status_t status,
    output skpl_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [3:0] {
        IDLE,
        CHECK,
        SORT_RD0,
        SORT_CARRY,
        SORT_PASS,
        SORT_END,
        SRCH_INIT,
        SRCH_TEST,
        SRCH_CMP
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    // commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (action)
                    begin
                        state_next = CHECK;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                    end
                end
            end
            CHECK:
            begin
                if (!status.is_sorted && status.count_ge2)
                begin
                    state_next = SORT_RD0;
                end
                else
                begin
                    cmd.mark_sorted = 1'b1;
                    state_next      = SRCH_INIT;
                end
            end
            SORT_RD0:
            begin
                cmd.pass_start = 1'b1;
                state_next     = SORT_CARRY;
            end
            SORT_CARRY:
            begin
                cmd.load_carry = 1'b1;
                state_next     = SORT_PASS;
            end
            SORT_PASS:
            begin
                cmd.pass_step = 1'b1;
                if (status.pass_last)
                begin
                    state_next = SORT_END;
                end
            end
            SORT_END:
            begin
                cmd.pass_end = 1'b1;
                if (status.swapped)
                begin
                    state_next = SORT_RD0;
                end
                else
                begin
                    cmd.mark_sorted = 1'b1;
                    state_next      = SRCH_INIT;
                end
            end
            SRCH_INIT:
            begin
                cmd.srch_init = 1'b1;
                state_next    = SRCH_TEST;
            end
            SRCH_TEST:
            begin
                if (status.srch_empty)
                begin
                    cmd.emit_miss = 1'b1;
                    state_next    = IDLE;
                end
                else
                begin
                    cmd.srch_read = 1'b1;
                    state_next    = SRCH_CMP;
                end
            end
            SRCH_CMP:
            begin
                cmd.srch_step = 1'b1;
                if (status.srch_hit)
                begin
                    state_next = IDLE;
                end
                else
                begin
                    state_next = SRCH_TEST;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // state and registered busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != IDLE;
        end
    end

    assign busy = busy_reg;

endmodule
